### src/hba_pkg.sv
`default_nettype none
package hba_pkg;

  localparam int ADDR_W = 20;
  localparam int SIZE_W = 21;
  localparam int NEED_W = 22;
  localparam int ALIGN_BYTES = 8;

  localparam int HEAP_BYTES_D = 1024 * 1024;
  localparam int MAX_BLOCKS_D = 64;
  localparam int HEADER_BYTES_D = 40;

  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_ZERO    = 3'd1;
  localparam logic [2:0] ST_NOFIT   = 3'd2;
  localparam logic [2:0] ST_FULL    = 3'd3;
  localparam logic [2:0] ST_UNKNOWN = 3'd4;

  localparam logic [1:0] STRAT_FIRST = 2'd0;
  localparam logic [1:0] STRAT_NEXT  = 2'd1;
  localparam logic [1:0] STRAT_BEST  = 2'd2;

  localparam logic REQ_ALLOC = 1'b0;
  localparam logic REQ_FREE  = 1'b1;

  typedef struct packed {
    logic [ADDR_W-1:0] start;
    logic [SIZE_W-1:0] size;
    logic              is_free;
  } entry_t;

endpackage
`default_nettype wire

### src/heap_block_allocator_top.sv
// Heap block allocator: keeps an address-ordered table of heap blocks in an
// on-chip memory and serves allocate and free requests one item at a time.
// Input channel: in_valid / in_stall with req_type, req_size, free_addr.
// Result channel: out_valid / out_stall with payload_addr and status, one
// result item per request item.
// Configuration: cfg_valid / cfg_ready write of the 2-bit placement policy
// (first, next or best fit); write it only while the block is idle.
// Timing: a request walks the table through one memory read port, one entry
// per cycle; a split moves the entries above the split point up by one, and a
// free with merge moves the entries above it down. Next fit may scan twice.
// in_stall stays high while an item is in work and for one cycle after reset
// while the first table entry is written. Reset leaves one free block that
// spans the heap minus one header, and the policy at first fit.
// A stalled result holds in the output register; the next item is accepted
// meanwhile, and its result waits until the register is free.
`default_nettype none
module heap_block_allocator_top #(
  parameter int HEAP_BYTES   = hba_pkg::HEAP_BYTES_D,
  parameter int MAX_BLOCKS   = hba_pkg::MAX_BLOCKS_D,
  parameter int HEADER_BYTES = hba_pkg::HEADER_BYTES_D
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     in_valid,
  output logic                          in_stall,
  input  wire logic                     in_req_type,
  input  wire logic [20:0]              in_req_size,
  input  wire logic [19:0]              in_free_addr,
  output logic                          out_valid,
  input  wire logic                     out_stall,
  output logic [19:0]                   out_payload_addr,
  output logic [2:0]                    out_status,
  input  wire logic                     cfg_valid,
  output logic                          cfg_ready,
  input  wire logic [1:0]               cfg_alloc_strategy
);

  localparam int IDX_W = $clog2(MAX_BLOCKS);
  localparam int CNT_W = $clog2(MAX_BLOCKS + 1);
  localparam int AW = hba_pkg::ADDR_W;
  localparam int SW = hba_pkg::SIZE_W;
  localparam int NW = hba_pkg::NEED_W;

  localparam logic [3:0] S_INIT   = 4'd0;
  localparam logic [3:0] S_IDLE   = 4'd1;
  localparam logic [3:0] S_PREP   = 4'd2;
  localparam logic [3:0] S_SCAN   = 4'd3;
  localparam logic [3:0] S_CLAIM  = 4'd4;
  localparam logic [3:0] S_SHR    = 4'd5;
  localparam logic [3:0] S_SPLIT  = 4'd6;
  localparam logic [3:0] S_SPLIT2 = 4'd7;
  localparam logic [3:0] S_NEXT   = 4'd8;
  localparam logic [3:0] S_MERGE  = 4'd9;
  localparam logic [3:0] S_SHL    = 4'd10;
  localparam logic [3:0] S_RESP   = 4'd11;

  localparam logic [2:0] P_FIND = 3'd0;
  localparam logic [2:0] P_FIT  = 3'd1;
  localparam logic [2:0] P_FIT0 = 3'd2;
  localparam logic [2:0] P_BEST = 3'd3;
  localparam logic [2:0] P_FREE = 3'd4;

  hba_pkg::entry_t mem [MAX_BLOCKS];
  hba_pkg::entry_t rdata_r;

  logic [3:0]       state_r, state_nxt;
  logic [2:0]       phase_r, phase_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [CNT_W-1:0] ptr_r, ptr_nxt;
  logic             ev_v_r, ev_v_nxt;
  logic [IDX_W-1:0] ev_idx_r, ev_idx_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  hba_pkg::entry_t  cur_r, cur_nxt;
  hba_pkg::entry_t  prev_r, prev_nxt;
  logic             found_r, found_nxt;
  logic             next_free_r, next_free_nxt;
  logic             prev_free_r, prev_free_nxt;
  logic [1:0]       d_r, d_nxt;
  logic [NW-1:0]    need_r, need_nxt;
  logic [AW-1:0]    key_r, key_nxt;
  logic [1:0]       strat_r;
  logic [AW-1:0]    nf_start_r, nf_start_nxt;
  logic             nf_valid_r, nf_valid_nxt;
  logic             req_type_r;
  logic [20:0]      req_size_r;
  logic [19:0]      free_addr_r;
  logic [19:0]      res_addr_r, res_addr_nxt;
  logic [2:0]       res_st_r, res_st_nxt;
  logic             out_valid_r;
  logic [19:0]      out_addr_r;
  logic [2:0]       out_st_r;

  logic             we;
  logic [IDX_W-1:0] wa;
  hba_pkg::entry_t  wd;
  logic [IDX_W-1:0] ra;

  logic             start_hit;
  logic             fit;
  logic [NW-1:0]    need_sum;
  logic [AW-1:0]    hdr_addr;
  logic             in_acc;
  logic             out_free;

  assign hdr_addr  = AW'(HEADER_BYTES);
  assign start_hit = (rdata_r.start == key_r);
  assign fit       = rdata_r.is_free && ({1'b0, rdata_r.size} >= need_r);
  assign need_sum  = NW'({1'b0, req_size_r}) + NW'(HEADER_BYTES) + NW'(hba_pkg::ALIGN_BYTES - 1);
  assign in_stall  = (state_r != S_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign cfg_ready = 1'b1;
  assign out_valid        = out_valid_r;
  assign out_payload_addr = out_addr_r;
  assign out_status       = out_st_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rdata_r <= mem[ra];
  end

  always_comb begin
    state_nxt     = state_r;
    phase_nxt     = phase_r;
    cnt_nxt       = cnt_r;
    ptr_nxt       = ptr_r;
    ev_v_nxt      = 1'b0;
    ev_idx_nxt    = ev_idx_r;
    idx_nxt       = idx_r;
    cur_nxt       = cur_r;
    prev_nxt      = prev_r;
    found_nxt     = found_r;
    next_free_nxt = next_free_r;
    prev_free_nxt = prev_free_r;
    d_nxt         = d_r;
    need_nxt      = need_r;
    key_nxt       = key_r;
    nf_start_nxt  = nf_start_r;
    nf_valid_nxt  = nf_valid_r;
    res_addr_nxt  = res_addr_r;
    res_st_nxt    = res_st_r;
    we            = 1'b0;
    wa            = '0;
    wd            = '0;
    ra            = ptr_r[IDX_W-1:0];

    case (state_r)
      S_INIT: begin
        we        = 1'b1;
        wa        = '0;
        wd.start  = '0;
        wd.size   = SW'(HEAP_BYTES - HEADER_BYTES);
        wd.is_free = 1'b1;
        state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_acc) begin
          state_nxt = S_PREP;
        end
      end
      S_PREP: begin
        ptr_nxt      = '0;
        found_nxt    = 1'b0;
        res_addr_nxt = '0;
        if (req_type_r == hba_pkg::REQ_FREE) begin
          if (free_addr_r < hdr_addr) begin
            res_st_nxt = hba_pkg::ST_UNKNOWN;
            state_nxt  = S_RESP;
          end else begin
            key_nxt   = free_addr_r - hdr_addr;
            phase_nxt = P_FREE;
            state_nxt = S_SCAN;
          end
        end else if (req_size_r == '0) begin
          res_st_nxt = hba_pkg::ST_ZERO;
          state_nxt  = S_RESP;
        end else begin
          need_nxt  = need_sum & ~NW'(hba_pkg::ALIGN_BYTES - 1);
          key_nxt   = nf_start_r;
          state_nxt = S_SCAN;
          if (strat_r == hba_pkg::STRAT_BEST) begin
            phase_nxt = P_BEST;
          end else if (strat_r == hba_pkg::STRAT_NEXT && nf_valid_r) begin
            phase_nxt = P_FIND;
          end else begin
            phase_nxt = P_FIT;
          end
        end
      end
      S_SCAN: begin
        // keep one read in flight, evaluate the entry read last cycle
        if (ptr_r < cnt_r) begin
          ev_v_nxt   = 1'b1;
          ev_idx_nxt = ptr_r[IDX_W-1:0];
          ptr_nxt    = ptr_r + CNT_W'(1);
        end
        if (ev_v_r) begin
          case (phase_r)
            P_FIND: begin
              if (start_hit) begin
                ptr_nxt   = CNT_W'(ev_idx_r);
                ev_v_nxt  = 1'b0;
                phase_nxt = P_FIT;
              end
            end
            P_FIT, P_FIT0: begin
              if (fit) begin
                cur_nxt   = rdata_r;
                idx_nxt   = ev_idx_r;
                state_nxt = S_CLAIM;
              end
            end
            P_BEST: begin
              if (fit && (!found_r || rdata_r.size < cur_r.size)) begin
                cur_nxt   = rdata_r;
                idx_nxt   = ev_idx_r;
                found_nxt = 1'b1;
              end
            end
            P_FREE: begin
              if (start_hit) begin
                cur_nxt   = rdata_r;
                idx_nxt   = ev_idx_r;
                state_nxt = S_NEXT;
              end else begin
                prev_nxt = rdata_r;
              end
            end
            default: begin
              state_nxt = S_IDLE;
            end
          endcase
        end else if (ptr_r >= cnt_r) begin
          res_st_nxt = hba_pkg::ST_NOFIT;
          case (phase_r)
            P_FIND: begin
              ptr_nxt   = '0;
              phase_nxt = P_FIT;
            end
            P_FIT: begin
              if (strat_r == hba_pkg::STRAT_NEXT) begin
                ptr_nxt   = '0;
                phase_nxt = P_FIT0;
              end else begin
                state_nxt = S_RESP;
              end
            end
            P_BEST: begin
              state_nxt = found_r ? S_CLAIM : S_RESP;
            end
            P_FREE: begin
              res_st_nxt = hba_pkg::ST_UNKNOWN;
              state_nxt  = S_RESP;
            end
            default: begin
              state_nxt = S_RESP;
            end
          endcase
        end
      end
      S_CLAIM: begin
        if ({1'b0, cur_r.size} == need_r) begin
          we           = 1'b1;
          wa           = idx_r;
          wd           = cur_r;
          wd.is_free   = 1'b0;
          res_st_nxt   = hba_pkg::ST_OK;
          res_addr_nxt = cur_r.start + hdr_addr;
          state_nxt    = S_RESP;
        end else if (cnt_r == CNT_W'(MAX_BLOCKS)) begin
          res_st_nxt = hba_pkg::ST_FULL;
          state_nxt  = S_RESP;
        end else begin
          ptr_nxt   = cnt_r - CNT_W'(1);
          state_nxt = S_SHR;
        end
      end
      S_SHR: begin
        // move entries above the split point up by one
        if (ev_v_r) begin
          we = 1'b1;
          wa = ev_idx_r + IDX_W'(1);
          wd = rdata_r;
        end
        if (ptr_r > CNT_W'(idx_r)) begin
          ev_v_nxt   = 1'b1;
          ev_idx_nxt = ptr_r[IDX_W-1:0];
          ptr_nxt    = ptr_r - CNT_W'(1);
        end else if (!ev_v_r) begin
          state_nxt = S_SPLIT;
        end
      end
      S_SPLIT: begin
        we         = 1'b1;
        wa         = idx_r + IDX_W'(1);
        wd.start   = AW'(NW'(cur_r.start) + need_r);
        wd.size    = SW'(NW'(cur_r.size) - need_r);
        wd.is_free = 1'b1;
        state_nxt  = S_SPLIT2;
      end
      S_SPLIT2: begin
        we           = 1'b1;
        wa           = idx_r;
        wd.start     = cur_r.start;
        wd.size      = SW'(need_r);
        wd.is_free   = 1'b0;
        cnt_nxt      = cnt_r + CNT_W'(1);
        nf_valid_nxt = 1'b1;
        nf_start_nxt = (strat_r == hba_pkg::STRAT_BEST) ? cur_r.start
                                                        : AW'(NW'(cur_r.start) + need_r);
        res_st_nxt   = hba_pkg::ST_OK;
        res_addr_nxt = cur_r.start + hdr_addr;
        state_nxt    = S_RESP;
      end
      S_NEXT: begin
        // rdata holds the following entry when one exists
        next_free_nxt = ev_v_r && rdata_r.is_free;
        prev_free_nxt = (idx_r != '0) && prev_r.is_free;
        if (ev_v_r && rdata_r.is_free) begin
          cur_nxt.size = cur_r.size + rdata_r.size;
        end
        state_nxt = S_MERGE;
      end
      S_MERGE: begin
        we           = 1'b1;
        wd.is_free   = 1'b1;
        res_st_nxt   = hba_pkg::ST_OK;
        res_addr_nxt = '0;
        d_nxt        = 2'({1'b0, next_free_r} + {1'b0, prev_free_r});
        if (prev_free_r) begin
          wa       = idx_r - IDX_W'(1);
          wd.start = prev_r.start;
          wd.size  = prev_r.size + cur_r.size;
          ptr_nxt  = CNT_W'(idx_r) + CNT_W'({1'b0, next_free_r}) + CNT_W'(1);
        end else begin
          wa       = idx_r;
          wd.start = cur_r.start;
          wd.size  = cur_r.size;
          ptr_nxt  = CNT_W'(idx_r) + CNT_W'(1) + CNT_W'({1'b0, next_free_r});
        end
        state_nxt = (next_free_r || prev_free_r) ? S_SHL : S_RESP;
      end
      S_SHL: begin
        // close the gap left by merged entries
        if (ev_v_r) begin
          we = 1'b1;
          wa = ev_idx_r - IDX_W'(d_r);
          wd = rdata_r;
        end
        if (ptr_r < cnt_r) begin
          ev_v_nxt   = 1'b1;
          ev_idx_nxt = ptr_r[IDX_W-1:0];
          ptr_nxt    = ptr_r + CNT_W'(1);
        end else if (!ev_v_r) begin
          cnt_nxt   = cnt_r - CNT_W'(d_r);
          state_nxt = S_RESP;
        end
      end
      S_RESP: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      cnt_r       <= CNT_W'(1);
      ev_v_r      <= 1'b0;
      nf_start_r  <= '0;
      nf_valid_r  <= 1'b0;
      strat_r     <= hba_pkg::STRAT_FIRST;
      out_valid_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      cnt_r      <= cnt_nxt;
      ev_v_r     <= ev_v_nxt;
      nf_start_r <= nf_start_nxt;
      nf_valid_r <= nf_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        strat_r <= cfg_alloc_strategy;
      end
      if (state_r == S_RESP && out_free) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    phase_r     <= phase_nxt;
    ptr_r       <= ptr_nxt;
    ev_idx_r    <= ev_idx_nxt;
    idx_r       <= idx_nxt;
    cur_r       <= cur_nxt;
    prev_r      <= prev_nxt;
    found_r     <= found_nxt;
    next_free_r <= next_free_nxt;
    prev_free_r <= prev_free_nxt;
    d_r         <= d_nxt;
    need_r      <= need_nxt;
    key_r       <= key_nxt;
    res_addr_r  <= res_addr_nxt;
    res_st_r    <= res_st_nxt;
    if (in_acc) begin
      req_type_r  <= in_req_type;
      req_size_r  <= in_req_size;
      free_addr_r <= in_free_addr;
    end
    if (state_r == S_RESP && out_free) begin
      out_addr_r <= res_addr_r;
      out_st_r   <= res_st_r;
    end
  end

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r != '0) && (cnt_r <= CNT_W'(MAX_BLOCKS)))
    else $error("block count out of range");

  a_cnt_change: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_INIT) && (cnt_nxt != cnt_r) |-> (state_r == S_SPLIT2 || state_r == S_SHL))
    else $error("block count changed outside split or merge");

  a_fail_no_addr: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_st_r != hba_pkg::ST_OK) |-> (out_addr_r == '0))
    else $error("failed request carries an address");

  a_shr_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SHR) |-> (ptr_r >= CNT_W'(idx_r)))
    else $error("shift ran below the split entry");

  a_result_load: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RESP) && out_free |=> out_valid_r && (state_r == S_IDLE))
    else $error("result not loaded on leaving response state");

endmodule
`default_nettype wire

### verif/heap_block_allocator_top_test.sv
`timescale 1ns / 100ps
`default_nettype none

class alloc_scoreboard;
  typedef struct {
    logic [19:0] payload_addr;
    logic [2:0]  status;
  } answer_t;

  typedef struct {
    int unsigned start;
    int unsigned size;
    bit          is_free;
  } blk_t;

  blk_t        blocks[$];
  int unsigned nf_start;
  bit          nf_valid;
  logic [1:0]  strategy;
  answer_t     pending[$];
  int          errors;
  int          checked;
  int          n_ok, n_nofit, n_full, n_unknown, n_zero;
  int unsigned live_addrs[$];

  function void reset_state();
    blk_t b;
    b.start = 0;
    b.size = hba_pkg::HEAP_BYTES_D - hba_pkg::HEADER_BYTES_D;
    b.is_free = 1;
    blocks = {};
    blocks.push_back(b);
    nf_start = 0;
    nf_valid = 0;
    strategy = hba_pkg::STRAT_FIRST;
    pending = {};
    live_addrs = {};
    errors = 0;
    checked = 0;
  endfunction

  function int scan_from(int from, int unsigned need);
    for (int i = from; i < blocks.size(); i++)
      if (blocks[i].is_free && blocks[i].size >= need) return i;
    return -1;
  endfunction

  function answer_t do_alloc(int unsigned req);
    answer_t a;
    int unsigned need;
    int pick, from;
    blk_t rest;
    a.payload_addr = 0;
    a.status = hba_pkg::ST_OK;
    if (req == 0) begin
      a.status = hba_pkg::ST_ZERO;
      return a;
    end
    need = (req + hba_pkg::HEADER_BYTES_D + 7) & ~32'd7;
    pick = -1;
    from = 0;
    if (strategy == hba_pkg::STRAT_BEST) begin
      for (int i = 0; i < blocks.size(); i++)
        if (blocks[i].is_free && blocks[i].size >= need)
          if (pick < 0 || blocks[i].size < blocks[pick].size) pick = i;
    end else if (strategy == hba_pkg::STRAT_NEXT) begin
      if (nf_valid)
        foreach (blocks[i])
          if (blocks[i].start == nf_start) begin
            from = i;
            break;
          end
      pick = scan_from(from, need);
      if (pick < 0) pick = scan_from(0, need);
    end else begin
      pick = scan_from(0, need);
    end
    if (pick < 0) begin
      a.status = hba_pkg::ST_NOFIT;
      return a;
    end
    if (blocks[pick].size != need) begin
      if (blocks.size() >= hba_pkg::MAX_BLOCKS_D) begin
        a.status = hba_pkg::ST_FULL;
        return a;
      end
      rest.start = blocks[pick].start + need;
      rest.size = blocks[pick].size - need;
      rest.is_free = 1;
      blocks.insert(pick + 1, rest);
      blocks[pick].size = need;
      nf_start = (strategy == hba_pkg::STRAT_BEST) ? blocks[pick].start : rest.start;
      nf_valid = 1;
    end
    blocks[pick].is_free = 0;
    a.payload_addr = 20'(blocks[pick].start + hba_pkg::HEADER_BYTES_D);
    live_addrs.push_back(a.payload_addr);
    return a;
  endfunction

  function answer_t do_free(int unsigned faddr);
    answer_t a;
    int idx;
    a.payload_addr = 0;
    a.status = hba_pkg::ST_UNKNOWN;
    if (faddr < hba_pkg::HEADER_BYTES_D) return a;
    idx = -1;
    foreach (blocks[i])
      if (blocks[i].start == faddr - hba_pkg::HEADER_BYTES_D) begin
        idx = i;
        break;
      end
    if (idx < 0) return a;
    a.status = hba_pkg::ST_OK;
    blocks[idx].is_free = 1;
    if (idx + 1 < blocks.size() && blocks[idx + 1].is_free) begin
      blocks[idx].size += blocks[idx + 1].size;
      blocks.delete(idx + 1);
    end
    if (idx > 0 && blocks[idx - 1].is_free) begin
      blocks[idx - 1].size += blocks[idx].size;
      blocks.delete(idx);
    end
    return a;
  endfunction

  function void note_request(logic req_type, logic [20:0] req_size, logic [19:0] faddr);
    answer_t a;
    if (req_type == hba_pkg::REQ_ALLOC) a = do_alloc(req_size);
    else a = do_free(faddr);
    case (a.status)
      hba_pkg::ST_OK:    n_ok++;
      hba_pkg::ST_ZERO:  n_zero++;
      hba_pkg::ST_NOFIT: n_nofit++;
      hba_pkg::ST_FULL:  n_full++;
      default:           n_unknown++;
    endcase
    pending.push_back(a);
  endfunction

  function void check_result(logic [19:0] addr, logic [2:0] status);
    answer_t a;
    checked++;
    if (pending.size() == 0) begin
      $error("unexpected result item: payload_addr %0h status %0d", addr, status);
      errors++;
      return;
    end
    a = pending.pop_front();
    if (addr !== a.payload_addr) begin
      $error("payload_addr: expected %0h, actual %0h", a.payload_addr, addr);
      errors++;
    end
    if (status !== a.status) begin
      $error("status: expected %0d, actual %0d", a.status, status);
      errors++;
    end
  endfunction
endclass

module heap_block_allocator_top_test;
  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic        in_req_type;
  logic [20:0] in_req_size;
  logic [19:0] in_free_addr;
  logic        out_valid;
  logic        out_stall;
  logic [19:0] out_payload_addr;
  logic [2:0]  out_status;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_alloc_strategy;

  alloc_scoreboard heap_sb;
  bit              sink_quiet;

  heap_block_allocator_top dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_req_type(in_req_type),
    .in_req_size(in_req_size), .in_free_addr(in_free_addr),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_payload_addr(out_payload_addr), .out_status(out_status),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_alloc_strategy(cfg_alloc_strategy)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // Send one request item, after a random gap; hold until accepted.
  task automatic send_request(logic req_type, logic [20:0] req_size, logic [19:0] faddr);
    int gap;
    gap = $urandom_range(0, 5);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_req_type <= req_type;
    in_req_size <= req_size;
    in_free_addr <= faddr;
    do @(posedge clk); while (!(in_valid && !in_stall));
    heap_sb.note_request(req_type, req_size, faddr);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (heap_sb.pending.size() != 0) @(posedge clk);
    repeat (3 * hba_pkg::MAX_BLOCKS_D + 20) @(posedge clk);
  endtask

  task automatic write_strategy(logic [1:0] value);
    cfg_valid <= 1'b1;
    cfg_alloc_strategy <= value;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    cfg_valid <= 1'b0;
    heap_sb.strategy = value;
  endtask

  task automatic random_alloc();
    logic [20:0] sz;
    case ($urandom_range(0, 9))
      0: sz = 21'($urandom_range(0, 2097151));
      1: sz = 21'($urandom_range(65536, 400000));
      2: sz = 0;
      default: sz = 21'($urandom_range(1, 4096));
    endcase
    send_request(hba_pkg::REQ_ALLOC, sz, 20'($urandom));
  endtask

  task automatic random_free();
    logic [19:0] fa;
    int k;
    if (heap_sb.live_addrs.size() != 0 && $urandom_range(0, 9) != 0) begin
      k = $urandom_range(0, heap_sb.live_addrs.size() - 1);
      fa = heap_sb.live_addrs[k];
      // keep some for a later double free
      if ($urandom_range(0, 7) != 0) heap_sb.live_addrs.delete(k);
    end else begin
      fa = 20'($urandom);
    end
    send_request(hba_pkg::REQ_FREE, 21'($urandom), fa);
  endtask

  // Sink: stall for a random count of cycles per item, sometimes not at all.
  initial begin
    int hold;
    out_stall = 1'b1;
    @(posedge rst_n);
    forever begin
      hold = sink_quiet ? 0 : $urandom_range(0, 5);
      if (hold != 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
      heap_sb.check_result(out_payload_addr, out_status);
    end
  end

  initial begin
    logic [1:0] plan[6];
    heap_sb = new();
    heap_sb.reset_state();
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_req_type = hba_pkg::REQ_ALLOC;
    in_req_size = '0;
    in_free_addr = '0;
    cfg_valid = 1'b0;
    cfg_alloc_strategy = hba_pkg::STRAT_FIRST;
    sink_quiet = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: zero size, extremes, unknown free, double free, no fit, merges.
    send_request(hba_pkg::REQ_ALLOC, 21'd0, 20'hFFFFF);
    send_request(hba_pkg::REQ_ALLOC, 21'h1FFFFF, 20'd0);
    send_request(hba_pkg::REQ_ALLOC, 21'd1048576, 20'd0);
    send_request(hba_pkg::REQ_FREE, 21'h1FFFFF, 20'd0);
    send_request(hba_pkg::REQ_FREE, 21'd0, 20'd39);
    send_request(hba_pkg::REQ_FREE, 21'd0, 20'hFFFFF);
    send_request(hba_pkg::REQ_ALLOC, 21'd1, 20'd0);
    send_request(hba_pkg::REQ_ALLOC, 21'd8, 20'd0);
    send_request(hba_pkg::REQ_ALLOC, 21'd100, 20'd0);
    send_request(hba_pkg::REQ_FREE, 21'd0, 20'd88);
    send_request(hba_pkg::REQ_FREE, 21'd0, 20'd88);
    send_request(hba_pkg::REQ_FREE, 21'd0, 20'd40);
    send_request(hba_pkg::REQ_FREE, 21'd0, 20'd136);
    // exact fit of the whole heap, then no room at all
    send_request(hba_pkg::REQ_ALLOC, 21'(hba_pkg::HEAP_BYTES_D - 2 * hba_pkg::HEADER_BYTES_D),
                 20'd0);
    send_request(hba_pkg::REQ_ALLOC, 21'd1, 20'd0);
    send_request(hba_pkg::REQ_FREE, 21'd0, 20'd40);
    wait_drained();

    plan = '{hba_pkg::STRAT_NEXT, hba_pkg::STRAT_BEST, 2'd3,
             hba_pkg::STRAT_FIRST, hba_pkg::STRAT_NEXT, hba_pkg::STRAT_BEST};
    foreach (plan[p]) begin
      write_strategy(plan[p]);
      sink_quiet = (p == 3);
      for (int n = 0; n < 258; n++) begin
        // bias toward allocation early so the table fills and overflows
        if ($urandom_range(0, 99) < ((n % 128) < 80 ? 70 : 35)) random_alloc();
        else random_free();
      end
      wait_drained();
    end

    $display("Covered %0d result items: %0d ok, %0d zero size, %0d no fit, %0d table full,",
             heap_sb.checked, heap_sb.n_ok, heap_sb.n_zero, heap_sb.n_nofit, heap_sb.n_full);
    $display("%0d unknown free, over all four placement settings.", heap_sb.n_unknown);
    if (heap_sb.errors == 0 && heap_sb.pending.size() == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

  initial begin
    #20ms;
    $display("Regression FAIL");
    $finish;
  end
endmodule

`default_nettype wire
